@@ hw/rtl/svc_pkg.sv @@
// shared types, constants and register codes of the scheduled valve controller
package svc_pkg;

  localparam int SVC_MAX_SLOTS      = 3;
  localparam int SVC_SLOT_COUNT_DEF = 3;

  localparam int SVC_HOUR_W   = 5;
  localparam int SVC_MINUTE_W = 6;
  localparam int SVC_SECOND_W = 6;
  localparam int SVC_DUR_W    = 16;
  localparam int SVC_TOTAL_W  = 32;
  localparam int SVC_KIND_W   = 2;

  localparam int SVC_CFG_IDX_W  = 3;
  localparam int SVC_CFG_DATA_W = 16;

  localparam int SVC_IN_FIELDS_W  = SVC_HOUR_W + SVC_MINUTE_W + SVC_SECOND_W;
  localparam int SVC_IN_TDATA_W   = ((SVC_IN_FIELDS_W + 7) / 8) * 8;
  localparam int SVC_OUT_FIELDS_W = 4 + SVC_MAX_SLOTS + SVC_TOTAL_W;
  localparam int SVC_OUT_TDATA_W  = ((SVC_OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SVC_HOUR_W-1:0]    SVC_RST_SLOT0_HOUR = 5'd6;
  localparam logic [SVC_HOUR_W-1:0]    SVC_RST_SLOT1_HOUR = 5'd18;
  localparam logic [SVC_HOUR_W-1:0]    SVC_RST_SLOT2_HOUR = 5'd12;
  localparam logic [SVC_MINUTE_W-1:0]  SVC_RST_MINUTE     = 6'd0;
  localparam logic [SVC_MAX_SLOTS-1:0] SVC_RST_ENABLE     = 3'd3;
  localparam logic [SVC_DUR_W-1:0]     SVC_RST_DURATION   = 16'd30;

  typedef enum logic [SVC_KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_CLOSE  = 2'd2
  } svc_kind_t;

  typedef enum logic [SVC_CFG_IDX_W-1:0] {
    REG_SLOT0_HOUR   = 3'd0,
    REG_SLOT0_MINUTE = 3'd1,
    REG_SLOT1_HOUR   = 3'd2,
    REG_SLOT1_MINUTE = 3'd3,
    REG_SLOT2_HOUR   = 3'd4,
    REG_SLOT2_MINUTE = 3'd5,
    REG_SLOT_ENABLE  = 3'd6,
    REG_DURATION     = 3'd7
  } svc_reg_t;

  typedef struct packed {
    logic [SVC_MAX_SLOTS-1:0][SVC_HOUR_W-1:0]   hour;
    logic [SVC_MAX_SLOTS-1:0][SVC_MINUTE_W-1:0] minute;
    logic [SVC_MAX_SLOTS-1:0]                   enable;
    logic [SVC_DUR_W-1:0]                       duration;
  } svc_cfg_t;

  typedef struct packed {
    logic                     valve_open;
    logic                     manual_active;
    logic                     opened_now;
    logic                     closed_now;
    logic [SVC_MAX_SLOTS-1:0] slot_hits;
    logic [SVC_TOTAL_W-1:0]   watering_total;
  } svc_result_t;

endpackage

@@ hw/rtl/svc_core.sv @@
// valve state, slot match tracking and hit total, one item per step
module svc_core
  import svc_pkg::*;
#(
  parameter int SLOT_COUNT = SVC_SLOT_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [SVC_KIND_W-1:0]   kind,
  input  logic [SVC_HOUR_W-1:0]   clock_hour,
  input  logic [SVC_MINUTE_W-1:0] clock_minute,
  input  logic [SVC_SECOND_W-1:0] clock_second,
  input  svc_cfg_t                cfg,
  output svc_result_t             res
);

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic                   valve_r, valve_nxt;
  logic                   manual_r, manual_nxt;
  logic [SVC_DUR_W-1:0]   elapsed_r, elapsed_nxt;
  logic [SLOT_COUNT-1:0]  prior_r, prior_nxt;
  logic [SVC_TOTAL_W-1:0] total_r, total_nxt;

  logic                     run, close_sched, check, sec_zero;
  logic                     valve_mid, manual_mid;
  logic [SVC_DUR_W-1:0]     elapsed_mid;
  logic [SVC_MAX_SLOTS-1:0] hits;
  logic [CNT_W-1:0]         hit_cnt;
  logic                     opened, closed;
  logic [SLOT_COUNT-1:0]    match;

  always_comb begin
    run         = valve_r & ~manual_r;
    elapsed_mid = elapsed_r;
    if (run && (elapsed_r != {SVC_DUR_W{1'b1}})) begin
      elapsed_mid = elapsed_r + 1'b1;
    end
    close_sched = run && (elapsed_mid >= cfg.duration);
    valve_mid   = valve_r & ~close_sched;
    manual_mid  = manual_r & ~close_sched;
    check       = ~valve_mid & ~manual_mid;
    sec_zero    = (clock_second == '0);

    hits    = '0;
    hit_cnt = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = (clock_hour == cfg.hour[i]) && (clock_minute == cfg.minute[i]) && sec_zero;
      if (check && cfg.enable[i] && match[i] && !prior_r[i]) begin
        hits[i] = 1'b1;
        hit_cnt = hit_cnt + 1'b1;
      end
    end

    valve_nxt   = valve_r;
    manual_nxt  = manual_r;
    elapsed_nxt = elapsed_r;
    prior_nxt   = prior_r;
    total_nxt   = total_r;
    opened      = 1'b0;
    closed      = 1'b0;

    case (kind)
      KIND_TICK: begin
        valve_nxt   = valve_mid;
        manual_nxt  = manual_mid;
        elapsed_nxt = elapsed_mid;
        closed      = close_sched;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (check && cfg.enable[i]) begin
            prior_nxt[i] = match[i];
          end
        end
        if (hits != '0) begin
          valve_nxt   = 1'b1;
          elapsed_nxt = '0;
          opened      = 1'b1;
        end
        total_nxt = total_r + SVC_TOTAL_W'(hit_cnt);
      end
      KIND_OPEN: begin
        if (!valve_r) begin
          valve_nxt   = 1'b1;
          manual_nxt  = 1'b1;
          elapsed_nxt = '0;
          opened      = 1'b1;
        end
      end
      KIND_CLOSE: begin
        if (valve_r && manual_r) begin
          valve_nxt  = 1'b0;
          manual_nxt = 1'b0;
          closed     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.valve_open     = valve_nxt;
    res.manual_active  = manual_nxt;
    res.opened_now     = opened;
    res.closed_now     = closed;
    res.slot_hits      = (kind == KIND_TICK) ? hits : '0;
    res.watering_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_r   <= 1'b0;
      manual_r  <= 1'b0;
      elapsed_r <= '0;
      prior_r   <= '0;
      total_r   <= '0;
    end else if (step) begin
      valve_r   <= valve_nxt;
      manual_r  <= manual_nxt;
      elapsed_r <= elapsed_nxt;
      prior_r   <= prior_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

@@ hw/rtl/scheduled_valve_controller.sv @@
// top level: configuration registers, valve core and result buffering
// Each item (a second tick with the time of day, or a remote open or close
// command) is evaluated in the cycle it transfers; its result is registered into
// the output register, or into the skid stage while that register holds an unread
// result. One item is taken per clock cycle while in_tready is high; a result
// register backed by a one-entry skid stage keeps the input ready while a result
// waits, so in_tready only drops when both hold unread results. Configuration
// writes are registered and should be made while no result is outstanding.
module scheduled_valve_controller
  import svc_pkg::*;
#(
  parameter int SLOT_COUNT = SVC_SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // clock_hour, clock_minute, clock_second
  input  logic [SVC_IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [SVC_KIND_W-1:0]      in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // valve_open, manual_active, opened_now, closed_now, slot_hits, watering_total
  output logic [SVC_OUT_TDATA_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic [SVC_CFG_IDX_W-1:0]   cfg_index,
  input  logic [SVC_CFG_DATA_W-1:0]  cfg_data
);

  svc_cfg_t    cfg_r;
  svc_result_t res;
  svc_result_t out_r, skid_r;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        accept, out_take, load_new, load_skid, skid_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hour     <= {SVC_RST_SLOT2_HOUR, SVC_RST_SLOT1_HOUR, SVC_RST_SLOT0_HOUR};
      cfg_r.minute   <= {SVC_RST_MINUTE, SVC_RST_MINUTE, SVC_RST_MINUTE};
      cfg_r.enable   <= SVC_RST_ENABLE;
      cfg_r.duration <= SVC_RST_DURATION;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT0_HOUR:   cfg_r.hour[0]   <= cfg_data[SVC_HOUR_W-1:0];
        REG_SLOT0_MINUTE: cfg_r.minute[0] <= cfg_data[SVC_MINUTE_W-1:0];
        REG_SLOT1_HOUR:   cfg_r.hour[1]   <= cfg_data[SVC_HOUR_W-1:0];
        REG_SLOT1_MINUTE: cfg_r.minute[1] <= cfg_data[SVC_MINUTE_W-1:0];
        REG_SLOT2_HOUR:   cfg_r.hour[2]   <= cfg_data[SVC_HOUR_W-1:0];
        REG_SLOT2_MINUTE: cfg_r.minute[2] <= cfg_data[SVC_MINUTE_W-1:0];
        REG_SLOT_ENABLE:  cfg_r.enable    <= cfg_data[SVC_MAX_SLOTS-1:0];
        REG_DURATION:     cfg_r.duration  <= cfg_data[SVC_DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = ~skid_valid_r;
  assign accept    = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;

  svc_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .kind         (in_tuser),
    .clock_hour   (in_tdata[SVC_HOUR_W-1:0]),
    .clock_minute (in_tdata[SVC_HOUR_W +: SVC_MINUTE_W]),
    .clock_second (in_tdata[SVC_HOUR_W+SVC_MINUTE_W +: SVC_SECOND_W]),
    .cfg          (cfg_r),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_new       = 1'b0;
    load_skid      = 1'b0;
    skid_load      = 1'b0;
    if (out_take) begin
      if (skid_valid_r) begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (!out_valid_r || out_take) begin
        load_new      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        skid_load      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      out_r <= res;
    end else if (load_skid) begin
      out_r <= skid_r;
    end
    if (skid_load) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = SVC_OUT_TDATA_W'({out_r.watering_total, out_r.slot_hits,
                                        out_r.closed_now, out_r.opened_now,
                                        out_r.manual_active, out_r.valve_open});

endmodule

@@ tb/scheduled_valve_controller_test.sv @@
// self-checking testbench of the scheduled valve controller with a valve status scoreboard
module scheduled_valve_controller_test
  import svc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SVC_KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int TOTAL_LSB      = 4 + SVC_MAX_SLOTS;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 108;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int MAX_PRINTED    = 30;

  class valve_status_scoreboard;
    logic [SVC_HOUR_W-1:0]    slot_hour[SVC_MAX_SLOTS];
    logic [SVC_MINUTE_W-1:0]  slot_minute[SVC_MAX_SLOTS];
    logic [SVC_MAX_SLOTS-1:0] enable_mask;
    logic [SVC_DUR_W-1:0]     duration;
    logic                     valve_on;
    logic                     manual_on;
    logic [SVC_DUR_W-1:0]     elapsed;
    logic [SVC_MAX_SLOTS-1:0] last_match;
    logic [SVC_TOTAL_W-1:0]   total;
    svc_result_t              valve_status_q[$];
    int                       errors;
    int                       checked;

    function new();
      slot_hour[0]   = SVC_RST_SLOT0_HOUR;
      slot_hour[1]   = SVC_RST_SLOT1_HOUR;
      slot_hour[2]   = SVC_RST_SLOT2_HOUR;
      slot_minute[0] = SVC_RST_MINUTE;
      slot_minute[1] = SVC_RST_MINUTE;
      slot_minute[2] = SVC_RST_MINUTE;
      enable_mask    = SVC_RST_ENABLE;
      duration       = SVC_RST_DURATION;
      valve_on       = 1'b0;
      manual_on      = 1'b0;
      elapsed        = '0;
      last_match     = '0;
      total          = '0;
      errors         = 0;
      checked        = 0;
    endfunction

    function void write_reg(svc_reg_t idx, logic [SVC_CFG_DATA_W-1:0] value);
      case (idx)
        REG_SLOT0_HOUR:   slot_hour[0] = value[SVC_HOUR_W-1:0];
        REG_SLOT0_MINUTE: slot_minute[0] = value[SVC_MINUTE_W-1:0];
        REG_SLOT1_HOUR:   slot_hour[1] = value[SVC_HOUR_W-1:0];
        REG_SLOT1_MINUTE: slot_minute[1] = value[SVC_MINUTE_W-1:0];
        REG_SLOT2_HOUR:   slot_hour[2] = value[SVC_HOUR_W-1:0];
        REG_SLOT2_MINUTE: slot_minute[2] = value[SVC_MINUTE_W-1:0];
        REG_SLOT_ENABLE:  enable_mask = value[SVC_MAX_SLOTS-1:0];
        REG_DURATION:     duration = value[SVC_DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [SVC_KIND_W-1:0] kind, logic [SVC_HOUR_W-1:0] hr,
                            logic [SVC_MINUTE_W-1:0] mn, logic [SVC_SECOND_W-1:0] sc);
      svc_result_t res;
      logic        hit;
      res = '0;
      if (kind == KIND_TICK) begin
        // a running scheduled watering counts first and may close
        if (valve_on && !manual_on) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (elapsed >= duration) begin
            valve_on = 1'b0;
            manual_on = 1'b0;
            res.closed_now = 1'b1;
          end
        end
        if (!valve_on && !manual_on) begin
          for (int i = 0; i < SVC_MAX_SLOTS; i++) begin
            if (enable_mask[i]) begin
              hit = (hr == slot_hour[i]) && (mn == slot_minute[i]) && (sc == '0);
              if (hit && !last_match[i]) begin
                if (!valve_on) begin
                  valve_on = 1'b1;
                  elapsed = '0;
                  res.opened_now = 1'b1;
                end
                total = total + 1'b1;
                res.slot_hits[i] = 1'b1;
              end
              last_match[i] = hit;
            end
          end
        end
      end else if (kind == KIND_OPEN) begin
        if (!valve_on) begin
          manual_on = 1'b1;
          valve_on = 1'b1;
          elapsed = '0;
          res.opened_now = 1'b1;
        end
      end else if (kind == KIND_CLOSE) begin
        if (valve_on && manual_on) begin
          valve_on = 1'b0;
          manual_on = 1'b0;
          res.closed_now = 1'b1;
        end
      end
      res.valve_open     = valve_on;
      res.manual_active  = manual_on;
      res.watering_total = total;
      valve_status_q.push_back(res);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_result(logic [SVC_OUT_TDATA_W-1:0] d);
      svc_result_t want;
      if (valve_status_q.size() == 0) begin
        report_mismatch("result with no item pending", d[31:0], '0);
      end else begin
        want = valve_status_q.pop_front();
        checked++;
        if (d[0] !== want.valve_open)
          report_mismatch("valve_open", 32'(d[0]), 32'(want.valve_open));
        if (d[1] !== want.manual_active)
          report_mismatch("manual_active", 32'(d[1]), 32'(want.manual_active));
        if (d[2] !== want.opened_now)
          report_mismatch("opened_now", 32'(d[2]), 32'(want.opened_now));
        if (d[3] !== want.closed_now)
          report_mismatch("closed_now", 32'(d[3]), 32'(want.closed_now));
        if (d[TOTAL_LSB-1:4] !== want.slot_hits)
          report_mismatch("slot_hits", 32'(d[TOTAL_LSB-1:4]), 32'(want.slot_hits));
        if (d[TOTAL_LSB +: SVC_TOTAL_W] !== want.watering_total)
          report_mismatch("watering_total", d[TOTAL_LSB +: SVC_TOTAL_W], want.watering_total);
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [SVC_IN_TDATA_W-1:0]  in_tdata = '0;
  logic [SVC_KIND_W-1:0]      in_tuser = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [SVC_OUT_TDATA_W-1:0] out_tdata;
  logic                       cfg_we = 1'b0;
  logic [SVC_CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SVC_CFG_DATA_W-1:0]  cfg_data = '0;

  valve_status_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  int kind_count[4];
  int settings_used = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [SVC_HOUR_W-1:0]   run_hour = '0;
  logic [SVC_MINUTE_W-1:0] run_minute = '0;
  logic [SVC_SECOND_W-1:0] run_second = '0;

  scheduled_valve_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: checks each transfer, then picks ready from its own stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (cycles[3:0] < 4'd10);
    endcase
  end

  task automatic write_reg(svc_reg_t idx, logic [SVC_CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.write_reg(idx, value);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_item(logic [SVC_KIND_W-1:0] kind, logic [SVC_HOUR_W-1:0] hr,
                           logic [SVC_MINUTE_W-1:0] mn, logic [SVC_SECOND_W-1:0] sc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(SVC_IN_TDATA_W - SVC_IN_FIELDS_W){1'b0}}, sc, mn, hr};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, hr, mn, sc);
    kind_count[kind]++;
  endtask

  // stop sending and let every outstanding transfer come back before a write
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.valve_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_phase_settings(int p);
    logic [SVC_CFG_DATA_W-1:0] v;
    for (int r = 0; r < 8; r++) begin
      if (p == 0) v = '0;
      else if (p == 2) v = '1;
      else if (r == REG_DURATION) begin
        if (p == 1 || p == 3) v = '0;
        else if ($urandom_range(0, 9) == 0) v = SVC_CFG_DATA_W'($urandom_range(13, 200));
        else v = SVC_CFG_DATA_W'($urandom_range(0, 12));
      end else if (p == 1) begin
        v = (r == REG_SLOT_ENABLE) ? 16'd7 : ((r % 2 == 0) ? 16'd23 : 16'd59);
      end else if ($urandom_range(0, 7) == 0) v = SVC_CFG_DATA_W'($urandom_range(0, 16'hFFFF));
      else if (r == REG_SLOT_ENABLE)
        v = (p == 3) ? 16'd7 : SVC_CFG_DATA_W'($urandom_range(0, 7));
      else if (r % 2 == 0) v = SVC_CFG_DATA_W'($urandom_range(0, 23));
      else v = SVC_CFG_DATA_W'($urandom_range(0, 59));
      write_reg(svc_reg_t'(r), v);
    end
    end_writes();
  endtask

  task automatic send_random_item();
    int k;
    int r;
    int slot;
    k = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    slot = $urandom_range(0, SVC_MAX_SLOTS - 1);
    if (k >= 72) begin
      if (k < 84)
        send_item(KIND_OPEN, SVC_HOUR_W'($urandom), SVC_MINUTE_W'($urandom),
                  SVC_SECOND_W'($urandom));
      else if (k < 96)
        send_item(KIND_CLOSE, SVC_HOUR_W'($urandom), SVC_MINUTE_W'($urandom),
                  SVC_SECOND_W'($urandom));
      else
        send_item(KIND_UNUSED, SVC_HOUR_W'($urandom), SVC_MINUTE_W'($urandom),
                  SVC_SECOND_W'($urandom));
    end else if (r < 45) begin
      send_item(KIND_TICK, sb.slot_hour[slot], sb.slot_minute[slot], '0);
    end else if (r < 65) begin
      send_item(KIND_TICK, sb.slot_hour[slot], sb.slot_minute[slot],
                SVC_SECOND_W'($urandom_range(0, 3)));
    end else if (r < 85) begin
      // wall clock running one second per tick
      if (run_second >= 59) begin
        run_second = '0;
        if (run_minute >= 59) begin
          run_minute = '0;
          run_hour = (run_hour >= 23) ? '0 : run_hour + 1'b1;
        end else begin
          run_minute = run_minute + 1'b1;
        end
      end else begin
        run_second = run_second + 1'b1;
      end
      send_item(KIND_TICK, run_hour, run_minute, run_second);
    end else begin
      send_item(KIND_TICK, SVC_HOUR_W'($urandom), SVC_MINUTE_W'($urandom),
                SVC_SECOND_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slot 0 and 1 share a time, slot 2 at the last minute of the day
    write_reg(REG_SLOT0_HOUR, 16'd0);
    write_reg(REG_SLOT0_MINUTE, 16'd0);
    write_reg(REG_SLOT1_HOUR, 16'd0);
    write_reg(REG_SLOT1_MINUTE, 16'd0);
    write_reg(REG_SLOT2_HOUR, 16'd23);
    write_reg(REG_SLOT2_MINUTE, 16'd59);
    write_reg(REG_SLOT_ENABLE, 16'd7);
    write_reg(REG_DURATION, 16'd1);
    end_writes();

    send_item(KIND_TICK, 5'd0, 6'd0, 6'd0);
    send_item(KIND_TICK, 5'd23, 6'd59, 6'd0);
    send_item(KIND_TICK, 5'd31, 6'd63, 6'd63);
    send_item(KIND_TICK, 5'd0, 6'd0, 6'd0);
    send_item(KIND_TICK, 5'd0, 6'd0, 6'd0);
    send_item(KIND_TICK, 5'd0, 6'd0, 6'd0);
    send_item(KIND_OPEN, 5'd0, 6'd0, 6'd0);
    send_item(KIND_OPEN, 5'd31, 6'd63, 6'd63);
    send_item(KIND_TICK, 5'd23, 6'd59, 6'd0);
    send_item(KIND_CLOSE, 5'd0, 6'd0, 6'd0);
    send_item(KIND_CLOSE, 5'd31, 6'd63, 6'd63);
    send_item(KIND_UNUSED, 5'd31, 6'd63, 6'd63);
    send_item(KIND_TICK, 5'd23, 6'd59, 6'd0);
    send_item(KIND_OPEN, 5'd0, 6'd0, 6'd0);
    send_item(KIND_CLOSE, 5'd0, 6'd0, 6'd0);
    send_item(KIND_TICK, 5'd0, 6'd0, 6'd30);
    send_item(KIND_TICK, 5'd0, 6'd0, 6'd31);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_phase_settings(p);
      run_hour = SVC_HOUR_W'($urandom_range(0, 23));
      run_minute = SVC_MINUTE_W'($urandom_range(0, 59));
      run_second = SVC_SECOND_W'($urandom_range(0, 59));
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end

    if (sb.valve_status_q.size() != 0)
      sb.report_mismatch("results still pending at end", sb.valve_status_q.size(), 0);
    $display("sent %0d ticks, %0d opens, %0d closes, %0d unused kinds over %0d settings",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], settings_used);
    $display("checked %0d results, final watering total %0d, %0d mismatches",
             sb.checked, sb.total, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
